FILE: hdl/assert_macros.svh
// Assertion macros for the console writer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define TCCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define TCCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCW_ASSERT(lbl, clk, rst, prop, msg)
`define TCCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/tccw_pkg.sv
// Package for the text console character writer: constants, state and
// register codes, and the controller/datapath command and status structs.
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0A20;
  localparam logic [3:0]  FG_RESET     = 4'd10;
  localparam logic [3:0]  BG_RESET     = 4'd0;

  localparam int CFG_INDEX_W = 2;
  localparam int POS_OUT_W   = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FG = 2'd0,
    REG_BG = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_SCROLL_END
  } state_t;

  typedef struct packed {
    logic accept;       // latch request, issue its read
    logic clear;        // reset sweep over the cell store
    logic exec;         // carry out the latched request
    logic scroll;       // copy sweep, one cell a cycle
    logic load;         // load result register
    logic res_scrolled;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic scroll_needed;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/text_console_char_writer_top.sv
// Text console character writer: a request is latched when taken, and a read
// or a plain put has its result loaded at the execute edge; a new request is
// taken only in idle, once the last one has executed and the result slot is empty or draining.
// A put that scrolls walks the whole cell store, one cell a cycle through the
// single-write, single-read store, before its result is loaded.
// After rst (synchronous, active high) a clearing pass fills every cell with
// 0x0A20, s_tready low; config writes are taken at any time.
`default_nettype none

module text_console_char_writer_top
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [23:0]            s_tdata,   // char_code[7:0], cell_address[18:8], pad
  input  wire logic                   s_tuser,   // req_type
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [31:0]                 m_tdata,   // cursor_position[10:0], cell_data[26:11]
  output logic                        m_tuser,   // scrolled
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [3:0]             cfg_data
);

  cmd_t                 cmd;
  status_t              status;
  logic [POS_OUT_W-1:0] res_pos;
  logic [15:0]          res_data;
  logic                 res_scrolled;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_read      (s_tuser),
    .in_char      (s_tdata[7:0]),
    .in_addr      (s_tdata[18:8]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res_pos      (res_pos),
    .res_data     (res_data),
    .res_scrolled (res_scrolled)
  );

  assign m_tdata = {5'b00000, res_data, res_pos};
  assign m_tuser = res_scrolled;

endmodule

`default_nettype wire

FILE: hdl/tccw_ctrl.sv
// Controller state machine for the console writer.
// Depends on tccw_pkg and assert_macros.svh; drives tccw_datapath by cmd_t.
`default_nettype none
`include "assert_macros.svh"

module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic   out_valid;
  logic   in_ready;

  assign in_ready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign s_tready = in_ready;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid && in_ready) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.scroll_needed ? ST_SCROLL : ST_IDLE;
      end
      ST_SCROLL: begin
        if (status.sweep_last) state_next = ST_SCROLL_END;
      end
      ST_SCROLL_END: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.accept       = s_tvalid && in_ready;
    cmd.clear        = (state == ST_CLEAR);
    cmd.exec         = (state == ST_EXEC);
    cmd.scroll       = (state == ST_SCROLL);
    cmd.load         = ((state == ST_EXEC) && !status.scroll_needed) ||
                       (state == ST_SCROLL_END);
    cmd.res_scrolled = (state == ST_SCROLL_END);
  end

  // Result slot is always empty by the time a load happens (drained at accept).
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  `TCCW_ASSERT(a_load_slot_free, clk, rst, cmd.load |-> !out_valid, "result overwritten")
  `TCCW_ASSERT(a_accept_to_exec, clk, rst, cmd.accept |=> state == ST_EXEC, "accept lost")
  `TCCW_ASSERT(a_scroll_end_order, clk, rst,
    state == ST_SCROLL_END |-> $past(state) == ST_SCROLL, "scroll end out of order")
  `TCCW_ASSERT_ALWAYS(a_no_accept_clear, clk,
    (state == ST_CLEAR || state == ST_SCROLL) |-> !s_tready, "request taken during sweep")

endmodule

`default_nettype wire

FILE: hdl/tccw_datapath.sv
// Datapath for the console writer: cell store, cursor, colour registers,
// sweep counter for clear and scroll, result register. Depends on tccw_pkg.
`default_nettype none

module tccw_datapath
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic                   in_read,
  input  wire logic [7:0]             in_char,
  input  wire logic [10:0]            in_addr,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [3:0]             cfg_data,
  output logic [POS_OUT_W-1:0]        res_pos,
  output logic [15:0]                 res_data,
  output logic                        res_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int POS_W = $clog2(CELLS + 1);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);

  logic [15:0]      mem [CELLS];
  logic [AW-1:0]    waddr, raddr, sweep, pend_addr;
  logic [15:0]      wdata, rdata, blank_cell, put_cell;
  logic             we, pend_valid, pend_blank;
  logic [3:0]       fg, bg;
  logic             req_read, addr_ok;
  logic [7:0]       req_char;
  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             newline, col_wrap, row_inc, scroll_needed;

  assign blank_cell = {bg, fg, CHAR_SPACE};
  assign put_cell   = {bg, fg, req_char};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG:  fg <= cfg_data;
        REG_BG:  bg <= cfg_data;
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_read <= in_read;
      req_char <= in_char;
      addr_ok  <= (32'(in_addr) < CELLS);
    end
  end

  // cursor update; pos tracks row*COLUMNS+col incrementally
  assign newline       = (req_char == CHAR_NEWLINE);
  assign col_wrap      = (col == COL_W'(COLUMNS - 1));
  assign row_inc       = newline || col_wrap;
  assign scroll_needed = !req_read && row_inc && (row == ROW_W'(ROWS - 1));

  always_comb begin
    row_next = row;
    col_next = col;
    pos_next = pos;
    if (cmd.exec && !req_read) begin
      if (scroll_needed) begin
        col_next = '0;
        pos_next = POS_W'(CELLS - COLUMNS);
      end else if (row_inc) begin
        row_next = row + 1'b1;
        col_next = '0;
        pos_next = pos - POS_W'(col) + POS_W'(COLUMNS);
      end else begin
        col_next = col + 1'b1;
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

  // sweep counter: reset clear and scroll copy
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clear || cmd.scroll) begin
      sweep <= sweep + 1'b1;
    end else begin
      sweep <= '0;
    end
  end

  // scroll: read cell k+COLUMNS now, write it to k next cycle (blank cell for the last row)
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.scroll;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= sweep;
    pend_blank <= (32'(sweep) >= CELLS - COLUMNS);
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(pos);
    wdata = put_cell;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = sweep;
      wdata = RESET_CELL;
    end else if (pend_valid) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = pend_blank ? blank_cell : rdata;
    end else if (cmd.exec && !req_read && !newline) begin
      we = 1'b1;
    end
  end

  assign raddr = cmd.scroll ? AW'(32'(sweep) + COLUMNS) : AW'(in_addr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_pos      <= POS_OUT_W'(pos_next);
      res_data     <= (req_read && addr_ok) ? rdata : 16'h0000;
      res_scrolled <= cmd.res_scrolled;
    end
  end

  assign status.sweep_last    = (sweep == AW'(CELLS - 1));
  assign status.scroll_needed = scroll_needed;

endmodule

`default_nettype wire

FILE: verif/text_console_char_writer_top_test.sv
// Self-checking bench for text_console_char_writer_top: random and directed
// put/read requests, colour register writes and a cell store shadow model.
// Depends on tccw_pkg and the top-level RTL only.
`default_nettype none

module text_console_char_writer_top_test;
  import tccw_pkg::*;

  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 20;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;
  // index with no register behind it; writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        is_read;
    logic [7:0]  ch;
    logic [10:0] addr;
  } console_req_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } console_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [31:0]            m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [3:0]             cfg_data = '0;

  text_console_char_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the console state
  logic [15:0] screen [CELL_COUNT];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [3:0]  fg_color;
  logic [3:0]  bg_color;

  console_req_t    request_queue[$];
  console_result_t pending_results[$];
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;

  function automatic console_result_t console_apply(console_req_t q);
    console_result_t r;
    int unsigned     pos;
    logic [15:0]     blank;
    int              i;
    r = '0;
    if (q.is_read == REQ_READ) begin
      if (q.addr < CELL_COUNT) r.cell_data = screen[q.addr];
    end else begin
      if (q.ch == CHAR_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELL_COUNT) screen[pos] = {bg_color, fg_color, q.ch};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row >= ROWS) begin
        blank = {bg_color, fg_color, CHAR_SPACE};
        for (i = 0; i + COLUMNS < CELL_COUNT; i++) screen[i] = screen[i + COLUMNS];
        for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen[i] = blank;
        cur_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_position = 11'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic console_req_t random_request(int unsigned newline_pct);
    console_req_t q;
    q.is_read = ($urandom_range(99) < 35) ? REQ_READ : REQ_PUT;
    q.ch      = 8'($urandom_range(255, 0));
    q.addr    = 11'($urandom_range(2047, 0));
    if (q.is_read == REQ_READ) begin
      // mostly inside the store, some past its end
      if ($urandom_range(7) != 0) q.addr = 11'($urandom_range(CELL_COUNT - 1, 0));
      else q.addr = 11'($urandom_range(2047, CELL_COUNT));
    end else if ($urandom_range(99) < newline_pct) begin
      q.ch = CHAR_NEWLINE;
    end
    return q;
  endfunction

  function automatic console_req_t make_request(logic is_read, logic [7:0] ch,
                                                logic [10:0] addr);
    console_req_t q;
    q.is_read = is_read;
    q.ch      = ch;
    q.addr    = addr;
    return q;
  endfunction

  task automatic write_color(logic [CFG_INDEX_W-1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FG) fg_color = val;
    else if (idx == REG_BG) bg_color = val;
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    console_req_t q;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        pending_results.push_back(console_apply(make_request(s_tuser, s_tdata[7:0],
                                                             s_tdata[18:8])));
      if (!s_tvalid || s_tready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          q = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= q.is_read;
          s_tdata  <= {5'b0, q.addr, q.ch};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, got tdata %h tuser %b", $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[10:0] !== want.cursor_position) begin
            $display("%0t: cursor_position expected %0d got %0d", $time,
                     want.cursor_position, m_tdata[10:0]);
            mismatch_count++;
          end
          if (m_tdata[26:11] !== want.cell_data) begin
            $display("%0t: cell_data expected %h got %h", $time, want.cell_data,
                     m_tdata[26:11]);
            mismatch_count++;
          end
          if (m_tuser !== want.scrolled) begin
            $display("%0t: scrolled expected %b got %b", $time, want.scrolled, m_tuser);
            mismatch_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int ph;
    int k;
    int unsigned nl_pct;
    for (k = 0; k < CELL_COUNT; k++) screen[k] = RESET_CELL;
    cur_row  = 0;
    cur_col  = 0;
    fg_color = FG_RESET;
    bg_color = BG_RESET;

    // directed: reset colours, store edges, reads past the end, newline handling
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'd0));
    request_queue.push_back(make_request(REQ_READ, 8'hFF, 11'(CELL_COUNT - 1)));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'(CELL_COUNT)));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'h7FF));
    request_queue.push_back(make_request(REQ_PUT, 8'h00, 11'h7FF));
    request_queue.push_back(make_request(REQ_PUT, 8'hFF, 11'h000));
    request_queue.push_back(make_request(REQ_PUT, 8'h41, 11'h555));
    request_queue.push_back(make_request(REQ_PUT, CHAR_NEWLINE, 11'h2AA));
    request_queue.push_back(make_request(REQ_PUT, 8'h09, 11'd0));
    request_queue.push_back(make_request(REQ_PUT, 8'h0B, 11'd0));
    request_queue.push_back(make_request(REQ_PUT, CHAR_SPACE, 11'd0));
    request_queue.push_back(make_request(REQ_PUT, CHAR_NEWLINE, 11'd0));
    request_queue.push_back(make_request(REQ_PUT, CHAR_NEWLINE, 11'd0));
    request_queue.push_back(make_request(REQ_PUT, 8'h7E, 11'd0));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'd0));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'd1));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'd2));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'd3));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'(COLUMNS)));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'(COLUMNS + 2)));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'(3 * COLUMNS)));
    request_queue.push_back(make_request(REQ_READ, 8'h00, 11'(3 * COLUMNS + 1)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_color(REG_FG, 4'h0);
          write_color(REG_BG, 4'hF);
          write_color(REG_UNUSED, 4'h9);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_color(REG_FG, 4'hF);
          write_color(REG_BG, 4'h0);
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          write_color(REG_FG, 4'($urandom_range(15)));
          write_color(REG_BG, 4'($urandom_range(15)));
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          write_color(REG_UNUSED, 4'($urandom_range(15)));
          write_color(REG_BG, 4'($urandom_range(15)));
          write_color(REG_FG, 4'($urandom_range(15)));
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      nl_pct = 0;
      for (k = 0; k < 100; k++) begin
        // stretches of plain text (column wrap) and of newline bursts (scrolls)
        if (k % 40 == 0) begin
          case ($urandom_range(2))
            0: nl_pct = 0;
            1: nl_pct = 10;
            default: nl_pct = 60;
          endcase
        end
        request_queue.push_back(random_request(nl_pct));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_ctrl.sv
hdl/tccw_datapath.sv
hdl/text_console_char_writer_top.sv
verif/text_console_char_writer_top_test.sv
